>>> rtl/rfalu_pkg.sv
// Shared types and constants for the register file ALU with flags.
package rfalu_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int IDX_W       = 4;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int STEP_W      = $clog2(DATA_W);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_CMP   = 3'd4,
    OP_MOV   = 3'd5,
    OP_WRITE = 3'd6,
    OP_READ  = 3'd7
  } op_e;

  typedef struct packed {
    logic ovf;
    logic sign;
    logic zero;
  } flags_t;

endpackage

>>> rtl/register_file_alu_with_flags_top.sv
// Register file ALU with zero, sign and overflow flags and a multicycle shared adder.
// Add, subtract, compare, move, write and read pass through ST_ALU and ST_WB before the
// output register; multiply and divide pass through ST_NEG_A, ST_NEG_B, 32 steps of the
// shared 33-bit adder in ST_ITER, and ST_FIX. A divide by zero is refused in ST_NEG_A.
// A new input transfer is taken only in the idle state, so an item cannot start before the
// last one is committed; a result still waiting at the output holds the next back.
// Reset is asynchronous: every register reads as zero and all flags are cleared at once.
module register_file_alu_with_flags_top #(
  parameter int REG_COUNT = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operation, dest_index, src_index, write_value, zero padding
  input  logic [rfalu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result_value, zero_flag, sign_flag, overflow_flag, divide_error, zero padding
  output logic [rfalu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int DW    = rfalu_pkg::DATA_W;
  localparam int AW    = $clog2(REG_COUNT);
  localparam int EXT_W = (AW > rfalu_pkg::IDX_W) ? AW : rfalu_pkg::IDX_W;
  localparam int SW    = rfalu_pkg::STEP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALU,
    ST_NEG_A,
    ST_NEG_B,
    ST_ITER,
    ST_FIX,
    ST_WB
  } state_e;

  state_e                    state_q;
  rfalu_pkg::op_e            op_q;
  logic [DW-1:0]             wv_q;
  logic [AW-1:0]             d_addr_q;
  logic                      d_ok_q;
  logic                      a_ok_q;
  logic                      b_ok_q;
  logic [DW-1:0]             rd_a_q;
  logic [DW-1:0]             rd_b_q;
  logic [DW-1:0]             a_q;
  logic [DW-1:0]             b_q;
  logic [DW-1:0]             hi_q;
  logic [DW-1:0]             lo_q;
  logic                      sa_q;
  logic                      sb_q;
  logic [SW-1:0]             cnt_q;
  logic [DW-1:0]             r_q;
  logic                      ovf_q;
  logic                      upd_q;
  logic                      wen_q;
  logic                      derr_q;
  rfalu_pkg::flags_t         flags_q;
  logic [REG_COUNT-1:0]      valid_q;
  logic [DW-1:0]             mem_q [REG_COUNT];
  logic                      m_valid_q;
  logic [DW-1:0]             out_r_q;
  rfalu_pkg::flags_t         out_flags_q;
  logic                      out_derr_q;

  rfalu_pkg::op_e            in_op;
  logic [EXT_W-1:0]          in_d_ext;
  logic [EXT_W-1:0]          in_s_ext;
  logic [AW-1:0]             in_d_addr;
  logic [AW-1:0]             in_s_addr;
  logic                      in_d_ok;
  logic                      in_s_ok;
  logic                      in_fire;
  logic                      out_free;
  logic                      commit;
  logic                      mem_we;
  logic [DW-1:0]             opa;
  logic [DW-1:0]             opb;
  logic [DW:0]               alu_x;
  logic [DW:0]               alu_y;
  logic                      alu_sub;
  logic [DW:0]               alu_s;
  logic                      div_ge;
  logic                      neg;
  logic                      mul_ovf;
  rfalu_pkg::flags_t         flags_new;

  assign in_op     = rfalu_pkg::op_e'(s_axis_tdata[2:0]);
  assign in_d_ext  = EXT_W'(s_axis_tdata[6:3]);
  assign in_s_ext  = EXT_W'(s_axis_tdata[10:7]);
  assign in_d_addr = in_d_ext[AW-1:0];
  assign in_s_addr = in_s_ext[AW-1:0];
  assign in_d_ok   = 32'(in_d_ext) < 32'(REG_COUNT);
  assign in_s_ok   = 32'(in_s_ext) < 32'(REG_COUNT);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign commit        = (state_q == ST_WB) && out_free;
  assign mem_we        = commit && wen_q && d_ok_q;

  assign opa = a_ok_q ? rd_a_q : '0;
  assign opb = b_ok_q ? rd_b_q : '0;

  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_ALU: begin
        alu_x   = {1'b0, opa};
        alu_y   = {1'b0, opb};
        alu_sub = (op_q != rfalu_pkg::OP_ADD);
      end
      ST_NEG_A: begin
        alu_y   = {1'b0, opa};
        alu_sub = 1'b1;
      end
      ST_NEG_B: begin
        alu_y   = {1'b0, b_q};
        alu_sub = 1'b1;
      end
      ST_ITER: begin
        if (op_q == rfalu_pkg::OP_MUL) begin
          alu_x = {1'b0, hi_q};
          alu_y = lo_q[0] ? {1'b0, a_q} : '0;
        end else begin
          alu_x   = {hi_q, lo_q[DW-1]};
          alu_y   = {1'b0, b_q};
          alu_sub = 1'b1;
        end
      end
      ST_FIX: begin
        alu_y   = {1'b0, lo_q};
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_s  = alu_x + (alu_sub ? ~alu_y : alu_y) + (DW+1)'(alu_sub);
  assign div_ge = !alu_s[DW];
  assign neg    = sa_q ^ sb_q;

  assign mul_ovf = (hi_q != '0) ||
                   (lo_q[DW-1] && (!neg || (lo_q[DW-2:0] != '0)));

  always_comb begin
    flags_new = flags_q;
    if (upd_q) begin
      flags_new.zero = (r_q == '0);
      flags_new.sign = r_q[DW-1];
      flags_new.ovf  = ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[d_addr_q] <= r_q;
    end
    rd_a_q <= mem_q[in_d_addr];
    rd_b_q <= mem_q[in_s_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flags_q     <= '0;
      valid_q     <= '0;
      m_valid_q   <= 1'b0;
      op_q        <= rfalu_pkg::OP_ADD;
      wv_q        <= '0;
      d_addr_q    <= '0;
      a_q         <= '0;
      b_q         <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      sa_q        <= 1'b0;
      sb_q        <= 1'b0;
      r_q         <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      upd_q       <= 1'b0;
      wen_q       <= 1'b0;
      derr_q      <= 1'b0;
      d_ok_q      <= 1'b0;
      a_ok_q      <= 1'b0;
      b_ok_q      <= 1'b0;
      out_r_q     <= '0;
      out_flags_q <= '0;
      out_derr_q  <= 1'b0;
    end else begin
      if (commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q     <= in_op;
            wv_q     <= s_axis_tdata[42:11];
            d_addr_q <= in_d_addr;
            d_ok_q   <= in_d_ok;
            a_ok_q   <= in_d_ok && valid_q[in_d_addr];
            b_ok_q   <= in_s_ok && valid_q[in_s_addr];
            if (in_op == rfalu_pkg::OP_MUL || in_op == rfalu_pkg::OP_DIV) begin
              state_q <= ST_NEG_A;
            end else begin
              state_q <= ST_ALU;
            end
          end
        end
        ST_ALU: begin
          derr_q  <= 1'b0;
          ovf_q   <= 1'b0;
          upd_q   <= 1'b0;
          wen_q   <= 1'b1;
          r_q     <= alu_s[DW-1:0];
          state_q <= ST_WB;
          unique case (op_q) inside
            rfalu_pkg::OP_ADD: begin
              upd_q <= 1'b1;
              ovf_q <= (opa[DW-1] ^ alu_s[DW-1]) & (opb[DW-1] ^ alu_s[DW-1]);
            end
            rfalu_pkg::OP_SUB, rfalu_pkg::OP_CMP: begin
              upd_q <= 1'b1;
              wen_q <= (op_q == rfalu_pkg::OP_SUB);
              ovf_q <= (opa[DW-1] ^ opb[DW-1]) & (opa[DW-1] ^ alu_s[DW-1]);
            end
            rfalu_pkg::OP_MOV: begin
              r_q <= opb;
            end
            rfalu_pkg::OP_WRITE: begin
              r_q <= wv_q;
            end
            default: begin
              r_q   <= opa;
              wen_q <= 1'b0;
            end
          endcase
        end
        ST_NEG_A: begin
          sa_q <= opa[DW-1];
          sb_q <= opb[DW-1];
          b_q  <= opb;
          if (op_q == rfalu_pkg::OP_DIV && opb == '0) begin
            r_q     <= opa;
            derr_q  <= 1'b1;
            upd_q   <= 1'b0;
            wen_q   <= 1'b0;
            state_q <= ST_WB;
          end else begin
            a_q     <= opa[DW-1] ? alu_s[DW-1:0] : opa;
            state_q <= ST_NEG_B;
          end
        end
        ST_NEG_B: begin
          b_q     <= sb_q ? alu_s[DW-1:0] : b_q;
          hi_q    <= '0;
          lo_q    <= (op_q == rfalu_pkg::OP_MUL) ? (sb_q ? alu_s[DW-1:0] : b_q) : a_q;
          cnt_q   <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          if (op_q == rfalu_pkg::OP_MUL) begin
            hi_q <= alu_s[DW:1];
            lo_q <= {alu_s[0], lo_q[DW-1:1]};
          end else begin
            hi_q <= div_ge ? alu_s[DW-1:0] : alu_x[DW-1:0];
            lo_q <= {lo_q[DW-2:0], div_ge};
          end
          cnt_q <= cnt_q + SW'(1);
          if (cnt_q == SW'(DW - 1)) begin
            state_q <= ST_FIX;
          end
        end
        ST_FIX: begin
          r_q     <= neg ? alu_s[DW-1:0] : lo_q;
          ovf_q   <= (op_q == rfalu_pkg::OP_MUL) ? mul_ovf : 1'b0;
          upd_q   <= 1'b1;
          wen_q   <= 1'b1;
          derr_q  <= 1'b0;
          state_q <= ST_WB;
        end
        ST_WB: begin
          if (out_free) begin
            flags_q     <= flags_new;
            out_r_q     <= r_q;
            out_flags_q <= flags_new;
            out_derr_q  <= derr_q;
            if (mem_we) begin
              valid_q[d_addr_q] <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, out_derr_q, out_flags_q.ovf, out_flags_q.sign,
                          out_flags_q.zero, out_r_q};

  a_flags_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(flags_q))
    else $error("Flags changed without a result being committed.");

  a_busy_after_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("Input taken again before the current instruction finished.");

  a_commit_gives_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_axis_tvalid && (state_q == ST_IDLE))
    else $error("Committed result did not reach the output register.");

  a_iter_ends_in_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER) && (cnt_q == SW'(DW - 1)) |=> (state_q == ST_FIX))
    else $error("Iteration count did not end the multiply or divide sequence.");

endmodule
